FILE: src/ascf_pkg.sv
// Shared types and constants for the actuator stall calibration block.
// Holds the request, response and register-file word formats and the phase,
// drive and request codes. No dependencies.
package ascf_pkg;

   localparam int MV_W       = 15;
   localparam int TIME_W     = 32;
   localparam int REQ_W      = 2;
   localparam int DRIVE_W    = 2;
   localparam int PHASE_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int FAIL_CNT_W = 8;

   // request codes
   localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_START  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_STOP   = 2'd2;
   localparam logic [REQ_W-1:0] REQ_TARGET = 2'd3;

   // phase codes
   localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_START = 3'd1;
   localparam logic [PHASE_W-1:0] PH_MIN   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_MAX   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_GOTO  = 3'd4;
   localparam logic [PHASE_W-1:0] PH_DONE  = 3'd5;
   localparam logic [PHASE_W-1:0] PH_FAIL  = 3'd6;

   // drive codes
   localparam logic [DRIVE_W-1:0] DRV_STOP = 2'd0;
   localparam logic [DRIVE_W-1:0] DRV_FWD  = 2'd1;
   localparam logic [DRIVE_W-1:0] DRV_BACK = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STABLE_THR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STABLE_TIME  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_TO    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GOTO_TO      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HYST_OFFSET  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FINAL_TOL    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERIM_TOL  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_AT_TGT_TOL   = 3'd7;

   typedef struct packed {
      logic [9:0]  stable_threshold_mv;
      logic [15:0] stable_time_ms;
      logic [15:0] search_timeout_ms;
      logic [15:0] goto_timeout_ms;
      logic [11:0] hysteresis_offset_mv;
      logic [9:0]  final_tolerance_mv;
      logic [9:0]  intermediate_tolerance_mv;
      logic [9:0]  at_target_tolerance_mv;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      stable_threshold_mv:       10'd20,
      stable_time_ms:            16'd1000,
      search_timeout_ms:         16'd12000,
      goto_timeout_ms:           16'd10000,
      hysteresis_offset_mv:      12'd150,
      final_tolerance_mv:        10'd20,
      intermediate_tolerance_mv: 10'd50,
      at_target_tolerance_mv:    10'd30
   };

   typedef struct packed {
      logic [REQ_W-1:0]  req_type;
      logic [MV_W-1:0]   voltage_mv;
      logic              sensor_ok;
      logic [TIME_W-1:0] now_ms;
      logic [MV_W-1:0]   target_mv;
   } req_word_type;

   typedef struct packed {
      logic [DRIVE_W-1:0] motor_drive;
      logic [PHASE_W-1:0] phase;
      logic               calibrating;
      logic               at_target;
      logic               result_valid;
      logic [MV_W-1:0]    min_mv;
      logic [MV_W-1:0]    max_mv;
   } rsp_word_type;

   function automatic logic [MV_W-1:0] abs_diff(input logic [MV_W-1:0] a,
                                                input logic [MV_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

FILE: src/actuator_stall_calibration_fsm.sv
// Top level of the actuator stall calibration controller: handshakes,
// register file, request and response registers. Depends on ascf_pkg, ascf_core.
//
// Use: each request word (sample tick, start calibration, stop, set target)
// on req_word with req_valid gives exactly one response word on rsp_word
// with rsp_valid, in order. A word moves when valid is high and stall low.
// The word passes the request register, then the state update and the response
// register; a stall on rsp_stall can hold it in the request register.
// Throughput is one word per cycle while rsp_stall is low; the state update is
// the loop that sets it. A stall on rsp_stall holds the response word; one more
// request is taken into the request register and then req_stall rises.
// Registers are written on csr_valid; csr_ready is high outside reset. Write
// them only while no word is in flight. Synchronous reset returns the state to
// idle with the actuator stopped, loads the register defaults and empties
// both registers; no word is accepted during reset.
module actuator_stall_calibration_fsm
   import ascf_pkg::*;
#(
   parameter int FAIL_LIMIT = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg_ff;
   logic         s1_vld_ff;
   req_word_type s1_word_ff;
   logic         rsp_vld_ff;
   rsp_word_type rsp_word_ff;
   rsp_word_type core_rsp;
   logic         advance;
   logic         req_take;

   assign csr_ready = !reset;
   assign advance   = s1_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = reset || (s1_vld_ff && !advance);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_word  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_STABLE_THR:  cfg_ff.stable_threshold_mv       <= csr_wdata[9:0];
            CSR_STABLE_TIME: cfg_ff.stable_time_ms            <= csr_wdata;
            CSR_SEARCH_TO:   cfg_ff.search_timeout_ms         <= csr_wdata;
            CSR_GOTO_TO:     cfg_ff.goto_timeout_ms           <= csr_wdata;
            CSR_HYST_OFFSET: cfg_ff.hysteresis_offset_mv      <= csr_wdata[11:0];
            CSR_FINAL_TOL:   cfg_ff.final_tolerance_mv        <= csr_wdata[9:0];
            CSR_INTERIM_TOL: cfg_ff.intermediate_tolerance_mv <= csr_wdata[9:0];
            CSR_AT_TGT_TOL:  cfg_ff.at_target_tolerance_mv    <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_take) begin
         s1_vld_ff <= 1'b1;
      end else if (advance) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff <= req_word;
      end
   end

   ascf_core #(
      .FAIL_LIMIT (FAIL_LIMIT)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .req_word (s1_word_ff),
      .cfg      (cfg_ff),
      .rsp_word (core_rsp)
   );

   // response register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= core_rsp;
      end
   end

   a_limits_zero_unless_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_word_ff.result_valid |->
         (rsp_word_ff.min_mv == '0) && (rsp_word_ff.max_mv == '0))
      else $error("limits shown without a valid result");

   a_at_target_in_goto: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_word_ff.at_target |-> rsp_word_ff.phase == PH_GOTO)
      else $error("at_target outside goto phase");

   a_drive_code_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_word_ff.motor_drive == DRV_STOP) ||
                     (rsp_word_ff.motor_drive == DRV_FWD) ||
                     (rsp_word_ff.motor_drive == DRV_BACK))
      else $error("illegal motor drive code");

   a_held_request_stays: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !advance |=> s1_vld_ff && $stable(s1_word_ff))
      else $error("pending request word lost");

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("processed word did not reach the response register");

endmodule

FILE: src/ascf_core.sv
// Calibration and target-approach state for the actuator controller.
// Updates its state from one request word per step and forms the response word.
// Depends on ascf_pkg.
module ascf_core
   import ascf_pkg::*;
#(
   parameter int FAIL_LIMIT = 20
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_word_type req_word,
   input  cfg_type      cfg,
   output rsp_word_type rsp_word
);

   localparam logic [FAIL_CNT_W:0] FAIL_LIMIT_N = (FAIL_CNT_W+1)'(FAIL_LIMIT);

   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [DRIVE_W-1:0]    motor_ff, motor_in;
   logic [TIME_W-1:0]     start_ff, start_in;
   logic [TIME_W-1:0]     since_ff, since_in;
   logic [MV_W-1:0]       last_ff, last_in;
   logic [MV_W-1:0]       lower_ff, lower_in;
   logic [MV_W-1:0]       upper_ff, upper_in;
   logic [MV_W-1:0]       final_ff, final_in;
   logic [MV_W-1:0]       interim_ff, interim_in;
   logic                  below_ff, below_in;
   logic [FAIL_CNT_W-1:0] fail_cnt_ff, fail_cnt_in;

   logic [MV_W-1:0]       v_eff;
   logic [FAIL_CNT_W:0]   fail_n;
   logic [TIME_W-1:0]     phase_el;
   logic [TIME_W-1:0]     stable_el;
   logic                  active;
   logic                  stalled;
   logic [MV_W-1:0]       goto_tgt;
   logic [9:0]            goto_tol;
   logic [MV_W:0]         lo_sum;
   logic [MV_W:0]         hi_sum;
   logic                  reached_below;
   logic                  result_ok;

   always_comb begin
      phase_in    = phase_ff;
      motor_in    = motor_ff;
      start_in    = start_ff;
      since_in    = since_ff;
      last_in     = last_ff;
      lower_in    = lower_ff;
      upper_in    = upper_ff;
      final_in    = final_ff;
      interim_in  = interim_ff;
      below_in    = below_ff;
      fail_cnt_in = fail_cnt_ff;

      // a failed read falls back on the last good sample
      v_eff     = req_word.sensor_ok ? req_word.voltage_mv : last_ff;
      fail_n    = {1'b0, fail_cnt_ff} + 1'b1;
      phase_el  = req_word.now_ms - start_ff;
      stable_el = req_word.now_ms - since_ff;
      active    = (phase_ff == PH_START) || (phase_ff == PH_MIN) ||
                  (phase_ff == PH_MAX) || (phase_ff == PH_GOTO);
      stalled   = abs_diff(v_eff, last_ff) <
                  {{(MV_W-10){1'b0}}, cfg.stable_threshold_mv};
      goto_tgt  = below_ff ? interim_ff : final_ff;
      goto_tol  = below_ff ? cfg.intermediate_tolerance_mv : cfg.final_tolerance_mv;
      lo_sum    = {1'b0, v_eff} + {{(MV_W-9){1'b0}}, goto_tol};
      hi_sum    = {1'b0, goto_tgt} + {{(MV_W-9){1'b0}}, goto_tol};
      reached_below = 1'b0;

      case (req_word.req_type)
         REQ_TICK: begin
            if (active) begin
               if (!req_word.sensor_ok && (fail_n > FAIL_LIMIT_N)) begin
                  motor_in    = DRV_STOP;
                  phase_in    = PH_FAIL;
                  fail_cnt_in = '0;
               end else begin
                  fail_cnt_in = req_word.sensor_ok ? '0 : fail_n[FAIL_CNT_W-1:0];
                  case (phase_ff)
                     PH_START: begin
                        start_in = req_word.now_ms;
                        since_in = req_word.now_ms;
                        last_in  = v_eff;
                        motor_in = DRV_BACK;
                        phase_in = PH_MIN;
                     end
                     PH_MIN, PH_MAX: begin
                        if (phase_el > {16'b0, cfg.search_timeout_ms}) begin
                           motor_in = DRV_STOP;
                           phase_in = PH_FAIL;
                        end else if (stalled) begin
                           if (stable_el > {16'b0, cfg.stable_time_ms}) begin
                              if (phase_ff == PH_MIN) begin
                                 // lower limit found: turn round at once
                                 lower_in = v_eff;
                                 start_in = req_word.now_ms;
                                 since_in = req_word.now_ms;
                                 last_in  = v_eff;
                                 motor_in = DRV_FWD;
                                 phase_in = PH_MAX;
                              end else begin
                                 upper_in = v_eff;
                                 motor_in = DRV_STOP;
                                 phase_in = PH_DONE;
                              end
                           end
                        end else begin
                           since_in = req_word.now_ms;
                           last_in  = v_eff;
                        end
                     end
                     PH_GOTO: begin
                        if (lo_sum < {1'b0, goto_tgt}) begin
                           motor_in = DRV_FWD;
                        end else if ({1'b0, v_eff} > hi_sum) begin
                           motor_in = DRV_BACK;
                        end else begin
                           motor_in = DRV_STOP;
                           if (below_ff) begin
                              reached_below = 1'b1;
                              below_in      = 1'b0;
                              start_in      = req_word.now_ms;
                           end
                        end
                        // reaching the interim point restarts the timer, so no timeout then
                        if (!reached_below && (phase_el > {16'b0, cfg.goto_timeout_ms})) begin
                           motor_in = DRV_STOP;
                           if (below_ff) begin
                              below_in = 1'b0;
                              start_in = req_word.now_ms;
                           end else begin
                              phase_in = PH_IDLE;
                           end
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         REQ_START: begin
            phase_in = PH_START;
         end
         REQ_STOP: begin
            phase_in = PH_IDLE;
            motor_in = DRV_STOP;
         end
         REQ_TARGET: begin
            phase_in = PH_GOTO;
            final_in = req_word.target_mv;
            start_in = req_word.now_ms;
            if (req_word.sensor_ok && (req_word.voltage_mv > req_word.target_mv)) begin
               // approach from below: aim one offset under the target, floor at zero
               if ({1'b0, req_word.target_mv} > {4'b0, cfg.hysteresis_offset_mv}) begin
                  interim_in = MV_W'({1'b0, req_word.target_mv} -
                                     {4'b0, cfg.hysteresis_offset_mv});
               end else begin
                  interim_in = '0;
               end
               below_in = 1'b1;
            end else begin
               interim_in = req_word.target_mv;
               below_in   = 1'b0;
            end
         end
         default: ;
      endcase

      result_ok = (phase_in == PH_DONE);
      rsp_word.motor_drive  = motor_in;
      rsp_word.phase        = phase_in;
      rsp_word.calibrating  = (phase_in == PH_START) || (phase_in == PH_MIN) ||
                              (phase_in == PH_MAX) || (phase_in == PH_GOTO);
      rsp_word.at_target    = (phase_in == PH_GOTO) && !below_in && req_word.sensor_ok &&
                              (abs_diff(req_word.voltage_mv, final_in) <
                               {{(MV_W-10){1'b0}}, cfg.at_target_tolerance_mv});
      rsp_word.result_valid = result_ok;
      rsp_word.min_mv       = result_ok ? lower_in : '0;
      rsp_word.max_mv       = result_ok ? upper_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         motor_ff    <= DRV_STOP;
         start_ff    <= '0;
         since_ff    <= '0;
         last_ff     <= '0;
         lower_ff    <= '0;
         upper_ff    <= '0;
         final_ff    <= '0;
         interim_ff  <= '0;
         below_ff    <= 1'b0;
         fail_cnt_ff <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         motor_ff    <= motor_in;
         start_ff    <= start_in;
         since_ff    <= since_in;
         last_ff     <= last_in;
         lower_ff    <= lower_in;
         upper_ff    <= upper_in;
         final_ff    <= final_in;
         interim_ff  <= interim_in;
         below_ff    <= below_in;
         fail_cnt_ff <= fail_cnt_in;
      end
   end

endmodule

FILE: test/actuator_stall_calibration_checker.sv
`timescale 1ns / 1ps
// Checker for the actuator stall calibration block: watches the request, response and
// register channels, predicts every response word and compares it field by field.
// Depends on ascf_pkg.
module actuator_stall_calibration_checker
   import ascf_pkg::*;
#(
   parameter int FAIL_LIMIT = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_word_type          req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_word_type          rsp_word,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    pending,
   output int                    fault_count
);

   // predicted controller state and register file
   cfg_type            cfg;
   logic [PHASE_W-1:0] ph;
   logic [DRIVE_W-1:0] drive;
   logic [TIME_W-1:0]  phase_t0;
   logic [TIME_W-1:0]  still_t0;
   logic [MV_W-1:0]    last_mv;
   logic [MV_W-1:0]    low_mv;
   logic [MV_W-1:0]    high_mv;
   logic [MV_W-1:0]    goal_mv;
   logic [MV_W-1:0]    via_mv;
   logic               via_pending;
   int unsigned        bad_reads;

   rsp_word_type status_q[$];

   initial begin
      pending     = 0;
      fault_count = 0;
   end

   function automatic logic [MV_W-1:0] mv_gap(input logic [MV_W-1:0] a,
                                              input logic [MV_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   task automatic note_fault(input string what);
      fault_count++;
      $display("%0t ns  mismatch: %s", $time, what);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         note_fault($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   task automatic clear_controller();
      cfg         = CFG_RESET;
      ph          = PH_IDLE;
      drive       = DRV_STOP;
      phase_t0    = '0;
      still_t0    = '0;
      last_mv     = '0;
      low_mv      = '0;
      high_mv     = '0;
      goal_mv     = '0;
      via_mv      = '0;
      via_pending = 1'b0;
      bad_reads   = 0;
   endtask

   task automatic apply_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_STABLE_THR:  cfg.stable_threshold_mv       = data[9:0];
         CSR_STABLE_TIME: cfg.stable_time_ms            = data;
         CSR_SEARCH_TO:   cfg.search_timeout_ms         = data;
         CSR_GOTO_TO:     cfg.goto_timeout_ms           = data;
         CSR_HYST_OFFSET: cfg.hysteresis_offset_mv      = data[11:0];
         CSR_FINAL_TOL:   cfg.final_tolerance_mv        = data[9:0];
         CSR_INTERIM_TOL: cfg.intermediate_tolerance_mv = data[9:0];
         CSR_AT_TGT_TOL:  cfg.at_target_tolerance_mv    = data[9:0];
         default: ;
      endcase
   endtask

   // one sample tick while a calibration or approach is running
   task automatic sample_tick(input logic [MV_W-1:0] v_in, input logic ok,
                              input logic [TIME_W-1:0] now);
      logic [MV_W-1:0]   v;
      logic [TIME_W-1:0] gone;
      int                aim_i;
      int                tol_i;
      int                v_i;
      bit                given_up;
      v        = v_in;
      given_up = 1'b0;
      if (!ok) begin
         if (bad_reads + 1 > FAIL_LIMIT) begin
            drive     = DRV_STOP;
            ph        = PH_FAIL;
            bad_reads = 0;
            given_up  = 1'b1;
         end else begin
            // hold the last good reading
            bad_reads = bad_reads + 1;
            v         = last_mv;
         end
      end else begin
         bad_reads = 0;
      end
      if (!given_up) begin
         case (ph)
            PH_START: begin
               phase_t0 = now;
               still_t0 = now;
               last_mv  = v;
               drive    = DRV_BACK;
               ph       = PH_MIN;
            end
            PH_MIN, PH_MAX: begin
               gone = now - phase_t0;
               if (gone > cfg.search_timeout_ms) begin
                  drive = DRV_STOP;
                  ph    = PH_FAIL;
               end else if (mv_gap(v, last_mv) < cfg.stable_threshold_mv) begin
                  gone = now - still_t0;
                  if (gone > cfg.stable_time_ms) begin
                     if (ph == PH_MIN) begin
                        // lower stop found: turn round at once
                        low_mv   = v;
                        phase_t0 = now;
                        still_t0 = now;
                        last_mv  = v;
                        drive    = DRV_FWD;
                        ph       = PH_MAX;
                     end else begin
                        high_mv = v;
                        drive   = DRV_STOP;
                        ph      = PH_DONE;
                     end
                  end
               end else begin
                  still_t0 = now;
                  last_mv  = v;
               end
            end
            PH_GOTO: begin
               aim_i = int'(via_pending ? via_mv : goal_mv);
               tol_i = int'(via_pending ? cfg.intermediate_tolerance_mv :
                                          cfg.final_tolerance_mv);
               v_i   = int'(v);
               if (v_i < aim_i - tol_i) begin
                  drive = DRV_FWD;
               end else if (v_i > aim_i + tol_i) begin
                  drive = DRV_BACK;
               end else begin
                  drive = DRV_STOP;
                  if (via_pending) begin
                     via_pending = 1'b0;
                     phase_t0    = now;
                  end
               end
               gone = now - phase_t0;
               if (gone > cfg.goto_timeout_ms) begin
                  drive = DRV_STOP;
                  // abandon the below-target step, or give up on the target
                  if (via_pending) begin
                     via_pending = 1'b0;
                     phase_t0    = now;
                  end else begin
                     ph = PH_IDLE;
                  end
               end
            end
            default: ;
         endcase
      end
   endtask

   task automatic step_controller(input req_word_type w, output rsp_word_type r);
      case (w.req_type)
         REQ_TICK: begin
            if (ph >= PH_START && ph <= PH_GOTO)
               sample_tick(w.voltage_mv, w.sensor_ok, w.now_ms);
         end
         REQ_START: ph = PH_START;
         REQ_STOP: begin
            ph    = PH_IDLE;
            drive = DRV_STOP;
         end
         REQ_TARGET: begin
            ph      = PH_GOTO;
            goal_mv = w.target_mv;
            if (w.sensor_ok && w.voltage_mv > w.target_mv) begin
               // come from below: aim one offset under the target first
               via_mv      = (w.target_mv > cfg.hysteresis_offset_mv) ?
                             w.target_mv - cfg.hysteresis_offset_mv : '0;
               via_pending = 1'b1;
            end else begin
               via_mv      = w.target_mv;
               via_pending = 1'b0;
            end
            phase_t0 = w.now_ms;
         end
         default: ;
      endcase
      r.motor_drive  = drive;
      r.phase        = ph;
      r.calibrating  = (ph >= PH_START && ph <= PH_GOTO);
      r.result_valid = (ph == PH_DONE);
      r.at_target    = (ph == PH_GOTO) && !via_pending && w.sensor_ok &&
                       (mv_gap(w.voltage_mv, goal_mv) < cfg.at_target_tolerance_mv);
      r.min_mv       = r.result_valid ? low_mv : '0;
      r.max_mv       = r.result_valid ? high_mv : '0;
   endtask

   always @(posedge clock) begin : watch
      rsp_word_type want;
      if (reset) begin
         clear_controller();
         status_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (status_q.size() == 0) begin
               note_fault("response word with nothing expected");
            end else begin
               want = status_q.pop_front();
               compare_field("motor_drive", 32'(rsp_word.motor_drive),
                             32'(want.motor_drive));
               compare_field("phase", 32'(rsp_word.phase), 32'(want.phase));
               compare_field("calibrating", 32'(rsp_word.calibrating),
                             32'(want.calibrating));
               compare_field("at_target", 32'(rsp_word.at_target), 32'(want.at_target));
               compare_field("result_valid", 32'(rsp_word.result_valid),
                             32'(want.result_valid));
               compare_field("min_mv", 32'(rsp_word.min_mv), 32'(want.min_mv));
               compare_field("max_mv", 32'(rsp_word.max_mv), 32'(want.max_mv));
            end
         end
         if (csr_valid && csr_ready)
            apply_csr(csr_index, csr_wdata);
         if (req_valid && !req_stall) begin
            step_controller(req_word, want);
            status_q.push_back(want);
         end
      end
      pending = status_q.size();
   end

endmodule

FILE: test/actuator_stall_calibration_fsm_test.sv
`timescale 1ns / 1ps
// Testbench top for the actuator stall calibration block: clock, reset, register
// settings and calibration / approach stimulus; the checker gives the verdict count.
// Depends on ascf_pkg, actuator_stall_calibration_fsm and the checker.
module actuator_stall_calibration_fsm_test;
   import ascf_pkg::*;

   localparam int FAIL_LIMIT  = 20;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 211;

   typedef enum int { SET_ZERO, SET_MAX, SET_RESET, SET_RANDOM } setting_kind_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int          pending;
   int          fault_count;
   int          cycle_count = 0;
   int          items_sent  = 0;
   bit          quiet       = 1'b0;
   logic [31:0] t_ms        = '0;
   cfg_type     cfg_now     = CFG_RESET;

   actuator_stall_calibration_fsm #(.FAIL_LIMIT(FAIL_LIMIT)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   actuator_stall_calibration_checker #(.FAIL_LIMIT(FAIL_LIMIT)) u_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .pending     (pending),
      .fault_count (fault_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (quiet)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < 21);
   end

   function automatic int clamp_mv(input int x);
      return (x < 0) ? 0 : (x > 32767) ? 32767 : x;
   endfunction

   function automatic req_word_type mk_word(input logic [REQ_W-1:0] kind, input int mv,
                                            input bit ok, input logic [31:0] stamp,
                                            input int goal);
      req_word_type w;
      w.req_type   = kind;
      w.voltage_mv = mv[MV_W-1:0];
      w.sensor_ok  = ok;
      w.now_ms     = stamp;
      w.target_mv  = goal[MV_W-1:0];
      return w;
   endfunction

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(input req_word_type w);
      // idle for a random number of cycles, about one in five overall
      while (!quiet && $urandom_range(0, 99) < 21) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_word  = w;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_sample(input int mv, input int dt, input bit ok);
      t_ms = t_ms + dt;
      send_word(mk_word(REQ_TICK, clamp_mv(mv), ok, t_ms, $urandom_range(0, 32767)));
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_index = idx;
      csr_wdata = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic load_settings(input cfg_type c);
      write_reg(CSR_STABLE_THR, 16'(c.stable_threshold_mv));
      write_reg(CSR_STABLE_TIME, c.stable_time_ms);
      write_reg(CSR_SEARCH_TO, c.search_timeout_ms);
      write_reg(CSR_GOTO_TO, c.goto_timeout_ms);
      write_reg(CSR_HYST_OFFSET, 16'(c.hysteresis_offset_mv));
      write_reg(CSR_FINAL_TOL, 16'(c.final_tolerance_mv));
      write_reg(CSR_INTERIM_TOL, 16'(c.intermediate_tolerance_mv));
      write_reg(CSR_AT_TGT_TOL, 16'(c.at_target_tolerance_mv));
      csr_valid = 1'b0;
      cfg_now   = c;
   endtask

   function automatic cfg_type pick_settings(input setting_kind_type kind);
      cfg_type c;
      case (kind)
         SET_ZERO:  c = '0;
         SET_MAX:   c = '1;
         SET_RESET: c = CFG_RESET;
         default: begin
            c.stable_threshold_mv       = 10'($urandom_range(1, 300));
            c.stable_time_ms            = 16'($urandom_range(0, 3000));
            c.search_timeout_ms         = 16'($urandom_range(3000, 30000));
            c.goto_timeout_ms           = 16'($urandom_range(1000, 20000));
            c.hysteresis_offset_mv      = ($urandom_range(0, 5) == 0) ? 12'hFFF :
                                          12'($urandom_range(0, 1500));
            c.final_tolerance_mv        = 10'($urandom_range(0, 150));
            c.intermediate_tolerance_mv = 10'($urandom_range(0, 150));
            c.at_target_tolerance_mv    = ($urandom_range(0, 5) == 0) ? 10'h3FF :
                                          10'($urandom_range(0, 150));
         end
      endcase
      return c;
   endfunction

   // start, drive down into the lower stop, then up into the upper stop
   task automatic run_calibration();
      int v;
      int dt;
      int steps;
      int jit;
      int base;
      int thr;
      thr = int'(cfg_now.stable_threshold_mv);
      send_word(mk_word(REQ_START, $urandom_range(0, 32767), 1'($urandom_range(0, 1)), t_ms,
                        $urandom_range(0, 32767)));
      v  = $urandom_range(8000, 32767);
      dt = cfg_now.stable_time_ms / $urandom_range(2, 6) + $urandom_range(1, 40);
      for (int leg = 0; leg < 2; leg++) begin
         steps = $urandom_range(1, 6);
         repeat (steps) begin
            jit = thr + $urandom_range(1, 600);
            v   = clamp_mv((leg == 0) ? v - jit : v + jit);
            send_sample(v, ($urandom_range(0, 49) == 0) ? dt + $urandom_range(0, 40000) : dt,
                        $urandom_range(0, 99) >= 6);
         end
         base  = v;
         steps = cfg_now.stable_time_ms / dt + $urandom_range(1, 3);
         if (steps > 30)
            steps = 30;
         repeat (steps) begin
            // keep within the stall band of the settled reading
            jit = (thr > 1) ? $urandom_range(0, thr - 1) : 0;
            send_sample((leg == 0) ? base + jit : base - jit, dt, $urandom_range(0, 99) >= 6);
         end
         if ($urandom_range(0, 11) == 0)
            send_word(mk_word(REQ_STOP, v, 1'b1, t_ms, 0));
      end
      repeat ($urandom_range(0, 2))
         send_sample(v, dt, 1'b1);
   endtask

   // set a target and wander towards the below-target point, then the target
   task automatic run_approach();
      int goal;
      int v;
      int via;
      int aim;
      int steps;
      int spread;
      int dt;
      goal = $urandom_range(0, 32767);
      v    = ($urandom_range(0, 1) == 1) ? $urandom_range(goal, 32767) : $urandom_range(0, goal);
      send_word(mk_word(REQ_TARGET, v, $urandom_range(0, 9) != 0, t_ms, goal));
      via    = (goal > cfg_now.hysteresis_offset_mv) ? goal - cfg_now.hysteresis_offset_mv : 0;
      steps  = $urandom_range(3, 16);
      spread = int'(cfg_now.final_tolerance_mv) + 10;
      dt     = cfg_now.goto_timeout_ms / $urandom_range(3, 8) + $urandom_range(1, 50);
      for (int i = 0; i < steps; i++) begin
         aim = (i < steps / 2) ? via : goal;
         v   = clamp_mv(v + (aim - v) / 2 + int'($urandom_range(0, 2 * spread)) - spread);
         send_sample(v, dt, $urandom_range(0, 99) >= 6);
      end
      if ($urandom_range(0, 5) == 0)
         send_word(mk_word(REQ_STOP, v, 1'b1, t_ms, goal));
   endtask

   // run of failed reads around the give-up count
   task automatic run_bad_reads();
      int v;
      v = $urandom_range(0, 32767);
      if ($urandom_range(0, 1) == 1)
         send_word(mk_word(REQ_START, v, 1'b1, t_ms, 0));
      else
         send_word(mk_word(REQ_TARGET, v, 1'b1, t_ms, $urandom_range(0, 32767)));
      send_sample(v, 10, 1'b1);
      repeat ($urandom_range(FAIL_LIMIT - 2, FAIL_LIMIT + 4))
         send_sample($urandom_range(0, 32767), $urandom_range(1, 50), 1'b0);
   endtask

   task automatic run_noise();
      repeat ($urandom_range(1, 5))
         send_word(mk_word(REQ_W'($urandom_range(0, 3)), $urandom_range(0, 32767),
                           1'($urandom_range(0, 1)), $urandom(), $urandom_range(0, 32767)));
   endtask

   initial begin
      int quota_end;
      int pick;
      setting_kind_type kind;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: idle ticks, a short full calibration, approaches and a wrapped timeout
      send_word(mk_word(REQ_TICK, 0, 1'b1, 32'h0000_0000, 0));
      send_word(mk_word(REQ_TICK, 32767, 1'b0, 32'hFFFF_FFFF, 32767));
      send_word(mk_word(REQ_STOP, 0, 1'b1, 0, 0));
      send_word(mk_word(REQ_START, 0, 1'b1, 100, 0));
      send_word(mk_word(REQ_TICK, 5000, 1'b1, 200, 0));
      send_word(mk_word(REQ_TICK, 4000, 1'b1, 300, 0));
      send_word(mk_word(REQ_TICK, 4005, 1'b1, 800, 0));
      send_word(mk_word(REQ_TICK, 4010, 1'b0, 1200, 0));
      send_word(mk_word(REQ_TICK, 4003, 1'b1, 1400, 0));
      send_word(mk_word(REQ_TICK, 6000, 1'b1, 1500, 0));
      send_word(mk_word(REQ_TICK, 6001, 1'b1, 2600, 0));
      send_word(mk_word(REQ_TICK, 6001, 1'b1, 2700, 0));
      send_word(mk_word(REQ_TARGET, 32767, 1'b1, 3000, 100));
      send_word(mk_word(REQ_TICK, 32767, 1'b1, 3100, 0));
      send_word(mk_word(REQ_TICK, 30, 1'b1, 3200, 0));
      send_word(mk_word(REQ_TICK, 110, 1'b1, 3300, 0));
      send_word(mk_word(REQ_TARGET, 0, 1'b0, 4000, 32767));
      send_word(mk_word(REQ_TICK, 0, 1'b1, 14001, 0));
      send_word(mk_word(REQ_TARGET, 0, 1'b1, 0, 0));
      send_word(mk_word(REQ_START, 0, 1'b1, 32'hFFFF_FF00, 0));
      send_word(mk_word(REQ_TICK, 20000, 1'b1, 32'hFFFF_FF00, 0));
      send_word(mk_word(REQ_TICK, 10000, 1'b1, 32'h0000_2F00, 0));
      send_word(mk_word(REQ_STOP, 32767, 1'b1, 0, 32767));
      wait_drained();

      t_ms = 32'd20000;
      for (int p = 0; p < PHASES; p++) begin
         kind = (p == 1) ? SET_ZERO : (p == 4) ? SET_MAX : (p == 6) ? SET_RESET : SET_RANDOM;
         load_settings(pick_settings(kind));
         quiet     = (p == 3);
         quota_end = items_sent + PHASE_ITEMS;
         if ($urandom_range(0, 2) == 0)
            t_ms = 32'hFFFF_FFFF - $urandom_range(0, 30000);
         while (items_sent < quota_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
               run_calibration();
            else if (pick < 72)
               run_approach();
            else if (pick < 82)
               run_bad_reads();
            else
               run_noise();
         end
         wait_drained();
      end
      quiet = 1'b0;

      repeat (4) @(negedge clock);
      if (fault_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
